/* design/assert_macros.svh */
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTOR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication, disabled during reset
`define PTOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

/* design/ptor_pkg.sv */
// types, constants and codes of the plate trail overlap recorder
package ptor_pkg;

    localparam int COORD_BITS        = 12;
    localparam int TICK_BITS         = 32;
    localparam int INDEX_BITS        = 4;
    localparam int COUNT_BITS        = 5;
    localparam int PCT_BITS          = 7;
    localparam int MAX_POSITIONS_DEF = 16;
    localparam int PERCENT_FULL      = 100;
    localparam int PADDR_BITS        = 3;
    localparam int PDATA_BITS        = 32;

    localparam logic [PCT_BITS-1:0] PCT_RESET = 7'd95;

    // item kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_SAMPLE = 2'd0;
    localparam t_kind KIND_CLEAR  = 2'd1;
    localparam t_kind KIND_READ   = 2'd2;

    // register index, taken from paddr above the byte lanes
    localparam logic [PADDR_BITS-3:0] REG_MIN_OVERLAP = 1'b0;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } t_box;

    typedef struct packed {
        t_box                 box;
        logic [TICK_BITS-1:0] tick;
    } t_entry;

    typedef struct packed {
        t_kind                 kind;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
        logic [TICK_BITS-1:0]  frame_tick;
        logic [INDEX_BITS-1:0] entry_index;
    } t_in_beat;

    typedef struct packed {
        logic                  recorded;
        logic                  rejected_overlap;
        logic                  rejected_full;
        logic [COUNT_BITS-1:0] trail_count;
        logic                  read_valid;
        logic [COORD_BITS-1:0] out_left;
        logic [COORD_BITS-1:0] out_top;
        logic [COORD_BITS-1:0] out_right;
        logic [COORD_BITS-1:0] out_bottom;
        logic [TICK_BITS-1:0]  out_tick;
    } t_out_beat;

    // status from the overlap unit back to the sequencer
    typedef struct packed {
        logic done;
        logic overlap;
    } t_ovl_stat;

endpackage

/* design/plate_trail_overlap_recorder.sv */
// plate trail overlap recorder: top level with sequencer, trail and apb register
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------
//   in      | sink      | i_valid / o_ready          | i_data (t_in_beat)
//   out     | source    | o_valid / i_ready          | o_data (t_out_beat)
//   apb     | slave     | psel, penable, pwrite, ... | pwdata / prdata
//
// a sample checked against the trail goes from accept to the next o_ready through
// trail fetch, load, then the overlap unit's five multiplier passes and done
// a read goes through fetch and load, a clear or a sample into an empty trail straight to done
// synchronous active-low reset empties the trail and loads min overlap 95
// a finished beat waits in the output register; the next item is taken
// meanwhile, and only its own result stalls until the output frees up
module plate_trail_overlap_recorder #(
    parameter int MAX_POSITIONS = ptor_pkg::MAX_POSITIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  ptor_pkg::t_in_beat              i_data,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output ptor_pkg::t_out_beat             o_data,
    // apb register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptor_pkg::PADDR_BITS-1:0] paddr,
    input  logic [ptor_pkg::PDATA_BITS-1:0] pwdata,
    output logic [ptor_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready
);
    import ptor_pkg::*;

    localparam int AW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int CW  = $clog2(MAX_POSITIONS + 1);
    localparam int IXW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
    localparam int OCW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
    localparam int AXW = (AW > INDEX_BITS) ? AW : INDEX_BITS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_in_beat            r_item;
    logic [CW-1:0]       r_count, n_count;
    logic [PCT_BITS-1:0] r_pct;
    t_out_beat           r_out, n_out;
    logic                r_out_valid;

    // trail memory and overlap unit hookup
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    t_entry        wr_data;
    t_entry        rd_data;
    t_box          sample_box;
    logic          ovl_start;
    t_ovl_stat     ovl_stat;

    logic           accept_in;
    logic           out_free;
    logic           finish;
    logic           count_zero;
    logic           count_full;
    logic [CW-1:0]  last_cnt;
    logic [AXW-1:0] idx_ext;
    logic           read_hit;
    logic           take;
    logic           rej_ovl;
    logic           rej_full;
    logic [OCW-1:0] cnt_ext;
    logic           reg_sel;

    assign o_ready   = (r_state == ST_IDLE);
    assign accept_in = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign finish    = (r_state == ST_DONE) && out_free;

    assign count_zero = (r_count == '0);
    assign count_full = (r_count == CW'(MAX_POSITIONS));
    assign last_cnt   = r_count - CW'(1);
    assign idx_ext    = AXW'(r_item.entry_index);
    assign read_hit   = IXW'(r_item.entry_index) < IXW'(r_count);

    assign sample_box = '{left: r_item.left, top: r_item.top,
                          right: r_item.right, bottom: r_item.bottom};

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    if ((i_data.kind == KIND_SAMPLE && !count_zero) ||
                        i_data.kind == KIND_READ) begin
                        n_state = ST_FETCH;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_FETCH: n_state = ST_LOAD;
            ST_LOAD: begin
                n_state = (r_item.kind == KIND_SAMPLE) ? ST_CHECK : ST_DONE;
            end
            ST_CHECK: begin
                if (ovl_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // fetch either the last stored entry or the entry asked for
    assign rd_en     = (r_state == ST_FETCH);
    assign rd_addr   = (r_item.kind == KIND_READ) ? idx_ext[AW-1:0] : last_cnt[AW-1:0];
    assign ovl_start = (r_state == ST_LOAD) && (r_item.kind == KIND_SAMPLE);

    // decision and result beat
    always_comb begin
        take     = 1'b0;
        rej_ovl  = 1'b0;
        rej_full = 1'b0;
        n_count  = r_count;
        case (r_item.kind)
            KIND_SAMPLE: begin
                if (count_zero) begin
                    take = 1'b1;
                end else if (ovl_stat.overlap) begin
                    rej_ovl = 1'b1;
                end else if (!count_full) begin
                    take = 1'b1;
                end else begin
                    rej_full = 1'b1;
                end
                if (take) begin
                    n_count = r_count + CW'(1);
                end
            end
            KIND_CLEAR: n_count = '0;
            default: begin
            end
        endcase

        cnt_ext = OCW'(n_count);
        n_out = '0;
        n_out.recorded         = take;
        n_out.rejected_overlap = rej_ovl;
        n_out.rejected_full    = rej_full;
        n_out.trail_count      = cnt_ext[COUNT_BITS-1:0];
        if (r_item.kind == KIND_READ && read_hit) begin
            n_out.read_valid = 1'b1;
            n_out.out_left   = rd_data.box.left;
            n_out.out_top    = rd_data.box.top;
            n_out.out_right  = rd_data.box.right;
            n_out.out_bottom = rd_data.box.bottom;
            n_out.out_tick   = rd_data.tick;
        end
    end

    // append at the current count
    assign wr_en   = finish && take;
    assign wr_data = '{box: sample_box, tick: r_item.frame_tick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_item <= i_data;
        end
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // apb register: min overlap percent
    assign reg_sel = (paddr[PADDR_BITS-1:2] == REG_MIN_OVERLAP);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDATA_BITS'(r_pct) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct <= PCT_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_pct <= pwdata[PCT_BITS-1:0];
        end
    end

    ptor_trail_mem #(
        .DEPTH (MAX_POSITIONS)
    ) u_trail (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ptor_overlap_unit u_overlap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ovl_start),
        .i_sample (sample_box),
        .i_stored (rd_data.box),
        .i_pct    (r_pct),
        .o_stat   (ovl_stat)
    );

endmodule

/* design/ptor_trail_mem.sv */
// trail storage: one write port, one registered read port
module ptor_trail_mem #(
    parameter int DEPTH = ptor_pkg::MAX_POSITIONS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  ptor_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output ptor_pkg::t_entry o_rd_data
);
    import ptor_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/ptor_overlap_unit.sv */
// overlap test over one shared multiplier, one product per cycle
module ptor_overlap_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  ptor_pkg::t_box                i_sample,
    input  ptor_pkg::t_box                i_stored,
    input  logic [ptor_pkg::PCT_BITS-1:0] i_pct,
    output ptor_pkg::t_ovl_stat           o_stat
);
    import ptor_pkg::*;

    localparam int DW     = COORD_BITS + 1;
    localparam int AREA_W = 2 * COORD_BITS + 1;
    localparam int CMP_W  = AREA_W + PCT_BITS;
    // widest product is the scaled smaller area
    localparam int MW     = CMP_W;

    typedef enum logic [6:0] {
        OS_IDLE   = 7'b0000001,
        OS_AREA_S = 7'b0000010,
        OS_AREA_C = 7'b0000100,
        OS_AREA_I = 7'b0001000,
        OS_NEED   = 7'b0010000,
        OS_HAVE   = 7'b0100000,
        OS_DECIDE = 7'b1000000
    } t_ostep;

    t_ostep r_step, n_step;
    logic   r_done;
    logic   r_overlap;
    logic   r_strict;

    logic [DW-1:0]     r_ws, r_hs, r_wc, r_hc, r_wi, r_hi;
    logic [AREA_W-1:0] r_area_s, r_area_c, r_area_i, r_smaller;
    logic [CMP_W-1:0]  r_need, r_have;

    logic [COORD_BITS-1:0] isect_l, isect_t, isect_r, isect_b;
    logic                  strict;
    logic [AREA_W-1:0]     mul_a;
    logic [DW-1:0]         mul_b;
    logic [MW-1:0]         product;

    // intersection corners
    always_comb begin
        isect_l = (i_sample.left   > i_stored.left)   ? i_sample.left   : i_stored.left;
        isect_t = (i_sample.top    > i_stored.top)    ? i_sample.top    : i_stored.top;
        isect_r = (i_sample.right  < i_stored.right)  ? i_sample.right  : i_stored.right;
        isect_b = (i_sample.bottom < i_stored.bottom) ? i_sample.bottom : i_stored.bottom;
        strict  = (isect_l < isect_r) && (isect_t < isect_b);
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_step)
            OS_AREA_S: begin
                mul_a = AREA_W'(r_ws);
                mul_b = r_hs;
            end
            OS_AREA_C: begin
                mul_a = AREA_W'(r_wc);
                mul_b = r_hc;
            end
            OS_AREA_I: begin
                mul_a = AREA_W'(r_wi);
                mul_b = r_hi;
            end
            OS_NEED: begin
                mul_a = r_smaller;
                mul_b = DW'(i_pct);
            end
            OS_HAVE: begin
                mul_a = r_area_i;
                mul_b = DW'(PERCENT_FULL);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = MW'(mul_a) * MW'(mul_b);
    end

    always_comb begin
        case (r_step)
            OS_IDLE:   n_step = i_start ? OS_AREA_S : OS_IDLE;
            OS_AREA_S: n_step = OS_AREA_C;
            OS_AREA_C: n_step = OS_AREA_I;
            OS_AREA_I: n_step = OS_NEED;
            OS_NEED:   n_step = OS_HAVE;
            OS_HAVE:   n_step = OS_DECIDE;
            OS_DECIDE: n_step = OS_IDLE;
            default:   n_step = OS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= OS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= (r_step == OS_DECIDE);
        end
    end

    // intersection side lengths are only meaningful when the strict intersection exists
    always_ff @(posedge i_clk) begin
        if (r_step == OS_IDLE && i_start) begin
            r_strict <= strict;
            r_ws <= DW'(i_sample.right)  - DW'(i_sample.left) + DW'(1);
            r_hs <= DW'(i_sample.bottom) - DW'(i_sample.top)  + DW'(1);
            r_wc <= DW'(i_stored.right)  - DW'(i_stored.left) + DW'(1);
            r_hc <= DW'(i_stored.bottom) - DW'(i_stored.top)  + DW'(1);
            r_wi <= DW'(isect_r) - DW'(isect_l) + DW'(1);
            r_hi <= DW'(isect_b) - DW'(isect_t) + DW'(1);
        end
        case (r_step)
            OS_AREA_S: r_area_s <= product[AREA_W-1:0];
            OS_AREA_C: r_area_c <= product[AREA_W-1:0];
            OS_AREA_I: begin
                r_area_i  <= product[AREA_W-1:0];
                r_smaller <= (r_area_s < r_area_c) ? r_area_s : r_area_c;
            end
            OS_NEED:   r_need <= product[CMP_W-1:0];
            OS_HAVE:   r_have <= product[CMP_W-1:0];
            OS_DECIDE: r_overlap <= r_strict && (r_have >= r_need);
            default: begin
            end
        endcase
    end

    assign o_stat = '{done: r_done, overlap: r_overlap};

endmodule

/* design/ptor_port_checker.sv */
// port checker for the plate trail overlap recorder, with its bind
`include "assert_macros.svh"

module ptor_port_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input ptor_pkg::t_out_beat o_data
);
    import ptor_pkg::*;

    logic [3:0] outcome_flags;

    assign outcome_flags = {o_data.recorded, o_data.rejected_overlap,
                            o_data.rejected_full, o_data.read_valid};

    // a waiting result beat stays up
    `PTOR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready), o_valid)

    // one item at a time: ready drops after every accepted beat
    `PTOR_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, (i_valid && o_ready), !o_ready)

    // at most one outcome flag per result
    `PTOR_ASSERT_NOW(a_one_flag, i_clk, i_rst_n, o_valid, ($countones(outcome_flags) <= 1))

    // an appended sample leaves a non-empty trail
    `PTOR_ASSERT_NOW(a_rec_count, i_clk, i_rst_n, (o_valid && o_data.recorded), (o_data.trail_count != '0))

endmodule

bind plate_trail_overlap_recorder ptor_port_checker u_port_checker (.*);

/* verif/trail_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// scoreboard class that predicts and checks the trail recorder result beats
package trail_check_pkg;
    import ptor_pkg::*;

    class trail_scoreboard;
        t_box                 trail_box  [MAX_POSITIONS_DEF];
        logic [TICK_BITS-1:0] trail_tick [MAX_POSITIONS_DEF];
        int unsigned          depth_used;
        logic [PCT_BITS-1:0]  min_pct;
        t_out_beat            due_q [$];
        int unsigned          errors;

        function new();
            depth_used = 0;
            min_pct    = PCT_RESET;
            errors     = 0;
        endfunction

        function void set_min_pct(logic [PCT_BITS-1:0] pct);
            min_pct = pct;
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // work out the result beat of one accepted item and queue it
        function void note_item(t_in_beat beat);
            t_out_beat             due;
            t_box                  s;
            t_box                  p;
            logic [COORD_BITS-1:0] il, it, ir, ib;
            logic [63:0]           area_s, area_p, area_i, smaller;
            bit                    hit;
            bit                    take;
            due  = '0;
            hit  = 1'b0;
            take = 1'b0;
            s.left   = beat.left;
            s.top    = beat.top;
            s.right  = beat.right;
            s.bottom = beat.bottom;
            case (beat.kind)
                KIND_SAMPLE: begin
                    if (depth_used == 0) begin
                        take = 1'b1;
                    end else begin
                        p  = trail_box[depth_used - 1];
                        il = (s.left   > p.left)   ? s.left   : p.left;
                        it = (s.top    > p.top)    ? s.top    : p.top;
                        ir = (s.right  < p.right)  ? s.right  : p.right;
                        ib = (s.bottom < p.bottom) ? s.bottom : p.bottom;
                        // empty strict intersection never counts as overlap
                        if (il < ir && it < ib) begin
                            area_s  = (64'(s.right) - 64'(s.left) + 64'd1)
                                    * (64'(s.bottom) - 64'(s.top) + 64'd1);
                            area_p  = (64'(p.right) - 64'(p.left) + 64'd1)
                                    * (64'(p.bottom) - 64'(p.top) + 64'd1);
                            area_i  = (64'(ir) - 64'(il) + 64'd1) * (64'(ib) - 64'(it) + 64'd1);
                            smaller = (area_s < area_p) ? area_s : area_p;
                            hit     = (64'(PERCENT_FULL) * area_i >= 64'(min_pct) * smaller);
                        end
                        if (hit)
                            due.rejected_overlap = 1'b1;
                        else if (depth_used < MAX_POSITIONS_DEF)
                            take = 1'b1;
                        else
                            due.rejected_full = 1'b1;
                    end
                    if (take) begin
                        trail_box[depth_used]  = s;
                        trail_tick[depth_used] = beat.frame_tick;
                        depth_used++;
                        due.recorded = 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    depth_used = 0;
                end
                KIND_READ: begin
                    if (beat.entry_index < depth_used) begin
                        due.read_valid = 1'b1;
                        due.out_left   = trail_box[beat.entry_index].left;
                        due.out_top    = trail_box[beat.entry_index].top;
                        due.out_right  = trail_box[beat.entry_index].right;
                        due.out_bottom = trail_box[beat.entry_index].bottom;
                        due.out_tick   = trail_tick[beat.entry_index];
                    end
                end
                default: begin
                end
            endcase
            due.trail_count = COUNT_BITS'(depth_used);
            due_q.push_back(due);
        endfunction

        // compare one result beat with the oldest prediction
        function void check_result(t_out_beat got);
            t_out_beat want;
            if (due_q.size() == 0) begin
                $error("result beat with no prediction waiting");
                errors++;
                return;
            end
            want = due_q.pop_front();
            check_field("recorded",         want.recorded,         got.recorded);
            check_field("rejected_overlap", want.rejected_overlap, got.rejected_overlap);
            check_field("rejected_full",    want.rejected_full,    got.rejected_full);
            check_field("trail_count",      want.trail_count,      got.trail_count);
            check_field("read_valid",       want.read_valid,       got.read_valid);
            check_field("out_left",         want.out_left,         got.out_left);
            check_field("out_top",          want.out_top,          got.out_top);
            check_field("out_right",        want.out_right,        got.out_right);
            check_field("out_bottom",       want.out_bottom,       got.out_bottom);
            check_field("out_tick",         want.out_tick,         got.out_tick);
        endfunction
    endclass

endpackage

/* verif/testbench.sv */
`timescale 1ns / 100ps
// top-level testbench of the plate trail overlap recorder
module testbench;
    import ptor_pkg::*;
    import trail_check_pkg::*;

    // the unused item kind, which the block only answers with the count
    localparam t_kind KIND_UNUSED = 2'd3;

    // cycles with no beat on either channel before the run is abandoned;
    // covers the long hold-off, the worst gaps and the sample path
    localparam int STALL_LIMIT     = 4000;
    // quiet cycles after the last result, well past the longest item latency
    localparam int DRAIN_CYCLES    = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int PHASE_ITEMS     = 100;
    localparam int NUM_PHASES      = 5;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

    localparam logic [PADDR_BITS-1:0] ADDR_MIN_OVERLAP = {REG_MIN_OVERLAP, 2'b00};

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_in_beat              i_data  = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out_beat             o_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_BITS-1:0] paddr   = '0;
    logic [PDATA_BITS-1:0] pwdata  = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    trail_scoreboard sb = new();

    int unsigned results_seen  = 0;
    int unsigned quiet_cycles  = 0;
    bit          tx_calm       = 1'b0;
    bit          rx_calm       = 1'b0;
    bit          hold_off_done = 1'b0;

    // last generated sample box, the base for near-threshold samples
    t_box anchor;
    bit   anchor_set = 1'b0;

    plate_trail_overlap_recorder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result monitor: every accepted result beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_data);
            results_seen++;
        end
    end

    // watchdog: counts cycles in which neither channel moves a beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // gap length: mostly none, some short, a few long
    function automatic int gap_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'(v);
    endfunction

    function automatic t_in_beat make_beat(t_kind k, int l, int t, int r, int b,
                                           logic [TICK_BITS-1:0] tick, int idx);
        t_in_beat beat;
        beat.kind        = k;
        beat.left        = COORD_BITS'(l);
        beat.top         = COORD_BITS'(t);
        beat.right       = COORD_BITS'(r);
        beat.bottom      = COORD_BITS'(b);
        beat.frame_tick  = tick;
        beat.entry_index = INDEX_BITS'(idx);
        return beat;
    endfunction

    // random item: mostly plausible plate samples near the previous one,
    // with reads, clears and raw noise mixed in
    function automatic t_in_beat random_item();
        t_in_beat beat;
        int       r;
        int       j;
        int       w;
        int       h;
        beat = t_in_beat'({$urandom, $urandom, $urandom});
        r    = $urandom_range(0, 99);
        if (r < 50) begin
            beat.kind = KIND_SAMPLE;
            if (anchor_set && $urandom_range(0, 2) != 0) begin
                // jittered copy of the last box, lands around the threshold
                j = $urandom_range(0, 12);
                beat.left   = clamp_coord(int'(anchor.left)   + int'($urandom_range(0, 2 * j)) - j);
                beat.top    = clamp_coord(int'(anchor.top)    + int'($urandom_range(0, 2 * j)) - j);
                beat.right  = clamp_coord(int'(anchor.right)  + int'($urandom_range(0, 2 * j)) - j);
                beat.bottom = clamp_coord(int'(anchor.bottom) + int'($urandom_range(0, 2 * j)) - j);
            end else begin
                w = $urandom_range(0, 400);
                h = $urandom_range(0, 300);
                beat.left   = COORD_BITS'($urandom_range(0, COORD_MAX - w));
                beat.top    = COORD_BITS'($urandom_range(0, COORD_MAX - h));
                beat.right  = beat.left + COORD_BITS'(w);
                beat.bottom = beat.top + COORD_BITS'(h);
            end
            anchor.left   = beat.left;
            anchor.top    = beat.top;
            anchor.right  = beat.right;
            anchor.bottom = beat.bottom;
            anchor_set    = 1'b1;
        end else if (r < 60) begin
            // raw sample, every field random, often inverted
            beat.kind = KIND_SAMPLE;
        end else if (r < 85) begin
            beat.kind = KIND_READ;
        end else if (r < 94) begin
            beat.kind = KIND_CLEAR;
        end else begin
            beat.kind = KIND_UNUSED;
        end
        return beat;
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input t_in_beat beat);
        int gap;
        gap = gap_len(tx_calm);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data  = beat;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(beat);
        @(negedge i_clk);
    endtask

    // wait for every predicted result, then let the block run dry
    task automatic settle();
        i_valid = 1'b0;
        while (sb.due_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_BITS-1:0] addr, input logic [PDATA_BITS-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check(input logic [PADDR_BITS-1:0] addr, input logic [PCT_BITS-1:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.check_field("min_overlap_percent", want, prdata[PCT_BITS-1:0]);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off so the
    // block fills up and pushes back on the item channel
    initial begin
        int stall;
        int cyc;
        stall = 0;
        cyc   = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (!hold_off_done && results_seen >= HOLD_OFF_AFTER) begin
                i_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else if (stall > 0) begin
                i_ready = 1'b0;
                stall--;
            end else begin
                i_ready = 1'b1;
                stall   = gap_len(rx_calm);
            end
        end
    end

    // main sequence: reset, directed items, random phases, drain, verdict
    initial begin
        logic [PCT_BITS-1:0] pct_plan [NUM_PHASES];
        int                  k;
        int                  ph;
        int                  n;

        pct_plan[0] = '0;
        pct_plan[1] = PCT_BITS'(PERCENT_FULL);
        pct_plan[2] = '1;
        pct_plan[3] = PCT_BITS'($urandom_range(1, PERCENT_FULL - 1));
        pct_plan[4] = PCT_RESET;

        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // threshold comes out of reset at its default
        apb_check(ADDR_MIN_OVERLAP, PCT_RESET);

        // directed: fill the whole trail so no entry stays unwritten
        send_item(make_beat(KIND_SAMPLE, 0, 0, 0, 0, '0, 0));
        // inverted box never overlaps
        send_item(make_beat(KIND_SAMPLE, COORD_MAX, COORD_MAX, 0, 0, '1, 15));
        send_item(make_beat(KIND_SAMPLE, 0, 0, COORD_MAX, COORD_MAX, $urandom, 0));
        // fully inside the full-frame box
        send_item(make_beat(KIND_SAMPLE, 100, 100, 199, 199, $urandom, 0));
        // single pixel: empty strict intersection
        send_item(make_beat(KIND_SAMPLE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, $urandom, 0));
        for (k = 0; k < 12; k++)
            send_item(make_beat(KIND_SAMPLE, k * 300 + 10, k * 300 + 10,
                                k * 300 + 210, k * 300 + 160, $urandom, 0));
        // trail full: disjoint box is refused for space, a repeat for overlap
        send_item(make_beat(KIND_SAMPLE, 3700, 10, 3900, 50, $urandom, 0));
        send_item(make_beat(KIND_SAMPLE, 3310, 3310, 3510, 3460, $urandom, 0));
        send_item(make_beat(KIND_READ, 0, 0, 0, 0, '0, 0));
        send_item(make_beat(KIND_READ, 0, 0, 0, 0, '0, 15));
        send_item(make_beat(KIND_READ, 0, 0, 0, 0, '0, 2));
        send_item(make_beat(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, 7));
        send_item(make_beat(KIND_CLEAR, 0, 0, 0, 0, '0, 0));
        // read past the stored count after the clear
        send_item(make_beat(KIND_READ, 0, 0, 0, 0, '0, 5));
        send_item(make_beat(KIND_SAMPLE, 500, 600, 700, 650, $urandom, 0));

        // random phases, each under its own threshold; upper data bits are noise
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            apb_write(ADDR_MIN_OVERLAP, {25'($urandom), pct_plan[ph]});
            sb.set_min_pct(pct_plan[ph]);
            apb_check(ADDR_MIN_OVERLAP, pct_plan[ph]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    tx_calm = ($urandom_range(0, 2) == 0);
                send_item(random_item());
            end
        end

        settle();
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* plate_trail_overlap_recorder.f */
+incdir+design
design/ptor_pkg.sv
design/ptor_trail_mem.sv
design/ptor_overlap_unit.sv
design/plate_trail_overlap_recorder.sv
design/ptor_port_checker.sv
verif/trail_scoreboard_pkg.sv
verif/testbench.sv
